FILE: rtl/plbk_pkg.sv
package plbk_pkg;

    localparam int K_MAX_DEF = 16;
    localparam int ID_W      = 24;
    localparam int DIST_W    = 32;
    localparam int KCFG_W    = 5;

    localparam logic REG_NEIGHBOURS_WANTED = 1'b0;
    localparam logic REG_SEARCH_RANGE      = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic emit_pop; // current output word taken, advance
    } plbk_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit_start; // accepted word ended a query
        logic emit_done;  // final output word taken
    } plbk_sts_t;

endpackage

FILE: rtl/plbk_ctrl.sv
module plbk_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               m_tready,
    output logic               m_tvalid,
    output plbk_pkg::plbk_cmd_t cmd,
    input  plbk_pkg::plbk_sts_t sts
);
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:  if (sts.emit_start) state_next = ST_EMIT;
            ST_EMIT: if (sts.emit_done) state_next = ST_RUN;
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_RUN;
        else state_reg <= state_next;
    end

    assign s_tready     = (state_reg == ST_RUN);
    assign m_tvalid     = (state_reg == ST_EMIT);
    assign cmd.accept   = s_tvalid && s_tready;
    assign cmd.emit_pop = m_tvalid && m_tready;

    a_no_accept_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !cmd.accept) else $error("accept during emit");
    a_emit_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.emit_start |=> m_tvalid) else $error("emit not started");
    a_done_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.emit_done |-> cmd.emit_pop) else $error("done without pop");
endmodule

FILE: rtl/plbk_dp.sv
module plbk_dp #(
    parameter int K_MAX = plbk_pkg::K_MAX_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic                         cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic [plbk_pkg::ID_W-1:0]    in_id,
    input  logic [plbk_pkg::DIST_W-1:0]  in_q,
    input  logic [plbk_pkg::DIST_W-1:0]  in_t,
    input  logic                         in_first,
    input  logic                         in_lastp,
    input  logic                         in_lasto,
    input  plbk_pkg::plbk_cmd_t          cmd,
    output plbk_pkg::plbk_sts_t          sts,
    output logic                         out_found,
    output logic [plbk_pkg::ID_W-1:0]    out_id,
    output logic [plbk_pkg::DIST_W-1:0]  out_bound,
    output logic                         out_last
);
    localparam int CW = $clog2(K_MAX + 1);
    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int DW = plbk_pkg::DIST_W;

    logic [plbk_pkg::KCFG_W-1:0] kcfg_reg;
    logic [DW-1:0]               range_reg;
    logic [DW-1:0]               rmax_reg;
    logic                        drop_reg;
    logic [DW:0]                 limit_reg;
    logic [DW-1:0]               bb_reg [K_MAX];
    logic [plbk_pkg::ID_W-1:0]   bi_reg [K_MAX];
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               ocnt_reg;
    logic [IW-1:0]               optr_reg;

    logic [CW-1:0] keff;
    logic [DW:0]   lim_cfg, lim0;
    logic [CW-1:0] cnt0, ccl;
    logic [DW-1:0] rmax0, diff, bnd;
    logic          drop0, dropped, ends, ins, full;
    logic [DW-1:0] kth;
    logic [K_MAX-1:0] gt;
    logic [CW-1:0] newc;
    logic [CW-1:0] cnt_upd;

    always_comb begin
        if (kcfg_reg == '0) keff = CW'(1);
        else if (32'(kcfg_reg) > K_MAX) keff = CW'(K_MAX);
        else keff = CW'(kcfg_reg);
    end

    assign lim_cfg = (range_reg == '0) ? {1'b1, {DW{1'b0}}} : {1'b0, range_reg};
    assign lim0  = in_first ? lim_cfg : limit_reg;
    assign cnt0  = in_first ? '0 : cnt_reg;
    assign rmax0 = in_first ? '0 : rmax_reg;
    assign drop0 = in_first ? 1'b0 : drop_reg;
    assign diff  = (in_q >= in_t) ? in_q - in_t : in_t - in_q;
    assign dropped = drop0 || ({1'b0, diff} > lim0);
    assign bnd   = (!dropped && diff > rmax0) ? diff : rmax0;
    assign ends  = in_lastp || in_lasto;
    assign ccl   = (cnt0 > keff) ? keff : cnt0;
    assign kth   = bb_reg[IW'(keff - CW'(1))];
    assign full  = (ccl == keff);
    assign ins   = ends && !dropped && !(full && bnd >= kth);
    assign newc  = full ? ccl : ccl + CW'(1);
    // held count is trimmed to k only when a surviving object is offered
    assign cnt_upd = ins ? newc : ((ends && !dropped) ? ccl : cnt0);

    always_comb begin
        for (int i = 0; i < K_MAX; i++) gt[i] = bb_reg[i] > bnd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kcfg_reg  <= plbk_pkg::KCFG_W'(1);
            range_reg <= '0;
            rmax_reg  <= '0;
            drop_reg  <= 1'b0;
            limit_reg <= {1'b1, {DW{1'b0}}};
            cnt_reg   <= '0;
            ocnt_reg  <= '0;
            optr_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == plbk_pkg::REG_NEIGHBOURS_WANTED)
                    kcfg_reg <= cfg_data[plbk_pkg::KCFG_W-1:0];
                else range_reg <= cfg_data;
            end
            if (cmd.accept) begin
                rmax_reg  <= ends ? '0 : bnd;
                drop_reg  <= ends ? 1'b0 : dropped;
                limit_reg <= lim0;
                cnt_reg   <= cnt_upd;
                if (ins) begin
                    // parallel sorted insert: shift entries above bnd up one
                    for (int i = 0; i < K_MAX; i++) begin
                        if (CW'(i) < newc) begin
                            if (gt[i] || CW'(i) >= ccl) begin
                                if (i == 0 || !gt[(i > 0) ? i - 1 : 0]
                                    || CW'(i - 1) >= ccl) begin
                                    bb_reg[i] <= bnd;
                                    bi_reg[i] <= in_id;
                                end else begin
                                    bb_reg[i] <= bb_reg[(i > 0) ? i - 1 : 0];
                                    bi_reg[i] <= bi_reg[(i > 0) ? i - 1 : 0];
                                end
                            end
                        end
                    end
                    // new last entry: bnd itself, or the one shifted up into it
                    if (newc == keff)
                        limit_reg <= {1'b0, (keff == CW'(1) || !gt[IW'(keff - CW'(2))])
                                      ? bnd : bb_reg[IW'(keff - CW'(2))]};
                end
                if (in_lasto) begin
                    ocnt_reg  <= cnt_upd;
                    optr_reg  <= '0;
                    cnt_reg   <= '0;
                    limit_reg <= lim_cfg;
                end
            end else if (cmd.emit_pop) begin
                optr_reg <= optr_reg + IW'(1);
            end
        end
    end

    assign sts.emit_start = cmd.accept && in_lasto;
    assign sts.emit_done  = cmd.emit_pop && out_last;
    assign out_found = (ocnt_reg != '0);
    assign out_id    = out_found ? bi_reg[optr_reg] : '0;
    assign out_bound = out_found ? bb_reg[optr_reg] : '0;
    assign out_last  = !out_found || (CW'(optr_reg) + CW'(1) == ocnt_reg);

    a_cnt_le_k: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg <= CW'(K_MAX)) else $error("count overflow");
    a_sorted01: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > CW'(1)) |-> (bb_reg[0] <= bb_reg[(K_MAX > 1) ? 1 : 0]))
        else $error("list unsorted");
    a_lim_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && !in_lasto && ins && newc == keff) |=> !limit_reg[DW])
        else $error("limit not set on full");
endmodule

FILE: rtl/pivot_lower_bound_knn_core.sv
// Pivot lower-bound best-k search. Each s_ word is one pivot element of a
// database object: |query_dist - table_dist| is folded into a running max
// per object (its lower bound); an element above the current limit drops the
// object. Surviving objects enter a sorted best-k list via a parallel
// compare-and-shift, and once k entries are held the limit tightens to the
// largest kept bound. Input words are taken one per cycle outside the emit
// phase. A word with last_object set ends the query; as it is taken the held
// count clears and the limit reloads from search_range. Input stalls while
// the list goes out on m_, one word per cycle while m_tready is high (count
// words, or one for an empty list with found=0). Config (cfg_index 0 =
// neighbours_wanted, 1 = search_range) is always ready; write only while idle.
module pivot_lower_bound_knn_core #(
    parameter int K_MAX = plbk_pkg::K_MAX_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: obj_index[23:0], query_dist[55:24], table_dist[87:56]
    input  logic [87:0]  s_tdata,
    // tuser: first_of_query[0], last_pivot[1]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,   // last_object
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: neighbour_id[23:0], lower_bound[55:24]
    output logic [55:0]  m_tdata,
    output logic         m_tuser,   // found
    output logic         m_tlast
);
    plbk_pkg::plbk_cmd_t cmd;
    plbk_pkg::plbk_sts_t sts;
    logic [plbk_pkg::ID_W-1:0]   oid;
    logic [plbk_pkg::DIST_W-1:0] obnd;

    assign cfg_ready = 1'b1;

    plbk_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tready, .m_tvalid, .cmd, .sts
    );

    plbk_dp #(.K_MAX(K_MAX)) u_dp (
        .aclk, .aresetn,
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_id     (s_tdata[23:0]),
        .in_q      (s_tdata[55:24]),
        .in_t      (s_tdata[87:56]),
        .in_first  (s_tuser[0]),
        .in_lastp  (s_tuser[1]),
        .in_lasto  (s_tlast),
        .cmd, .sts,
        .out_found (m_tuser),
        .out_id    (oid),
        .out_bound (obnd),
        .out_last  (m_tlast)
    );

    assign m_tdata = {obnd, oid};
endmodule

FILE: verif/pivot_lower_bound_knn_checker.sv
module pivot_lower_bound_knn_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic        found;
        logic [23:0] id;
        logic [31:0] bound;
        logic        last;
    } nbr_word_t;

    nbr_word_t   nbr_q[$];
    logic [4:0]  k_reg;
    logic [31:0] range_reg;
    logic [31:0] run_max;
    logic        dropped;
    logic [32:0] limit;
    logic [31:0] keep_bound[16];
    logic [23:0] keep_id[16];
    int          keep_n;

    assign pending = nbr_q.size();

    function automatic int kk();
        if (k_reg == 0) return 1;
        if (k_reg > 16) return 16;
        return int'(k_reg);
    endfunction

    function automatic logic [32:0] range_limit();
        return (range_reg == 0) ? 33'h1_0000_0000 : {1'b0, range_reg};
    endfunction

    task automatic insert_cand(input logic [31:0] b, input logic [23:0] id);
        int k, p;
        k = kk();
        if (keep_n > k) keep_n = k;
        if (keep_n == k) begin
            if (b >= keep_bound[k-1]) return;
            keep_n = k - 1;
        end
        p = keep_n;
        while (p > 0 && keep_bound[p-1] > b) begin
            keep_bound[p] = keep_bound[p-1];
            keep_id[p] = keep_id[p-1];
            p--;
        end
        keep_bound[p] = b;
        keep_id[p] = id;
        keep_n++;
        if (keep_n == k) limit = {1'b0, keep_bound[k-1]};
    endtask

    task automatic pivot_step(input logic [87:0] d, input logic [1:0] u, input logic lo);
        logic [31:0] q, t, df;
        nbr_word_t w;
        q = d[55:24];
        t = d[87:56];
        if (u[0]) begin
            keep_n = 0;
            limit = range_limit();
            run_max = 0;
            dropped = 0;
        end
        df = (q >= t) ? q - t : t - q;
        if ({1'b0, df} > limit) dropped = 1;
        else if (df > run_max) run_max = df;
        if (u[1] || lo) begin
            if (!dropped) insert_cand(run_max, d[23:0]);
            run_max = 0;
            dropped = 0;
        end
        if (lo) begin
            if (keep_n == 0) begin
                w = '{found: 1'b0, id: '0, bound: '0, last: 1'b1};
                nbr_q.push_back(w);
            end else begin
                for (int i = 0; i < keep_n; i++) begin
                    w = '{found: 1'b1, id: keep_id[i], bound: keep_bound[i],
                          last: (i + 1 == keep_n)};
                    nbr_q.push_back(w);
                end
            end
            keep_n = 0;
            limit = range_limit();
        end
    endtask

    always @(posedge aclk) begin
        nbr_word_t e;
        if (!aresetn) begin
            k_reg <= 5'd1;
            range_reg <= '0;
            run_max <= '0;
            dropped <= 1'b0;
            limit <= 33'h1_0000_0000;
            keep_n <= 0;
            fail_count <= 0;
            nbr_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == plbk_pkg::REG_NEIGHBOURS_WANTED) k_reg = cfg_data[4:0];
                else range_reg = cfg_data;
            end
            if (s_tvalid && s_tready) pivot_step(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (nbr_q.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    e = nbr_q.pop_front();
                    if (m_tuser !== e.found) begin
                        $error("found: exp %0d got %0d", e.found, m_tuser); fail_count++;
                    end
                    if (m_tdata[23:0] !== e.id) begin
                        $error("neighbour_id: exp %0h got %0h", e.id, m_tdata[23:0]);
                        fail_count++;
                    end
                    if (m_tdata[55:24] !== e.bound) begin
                        $error("lower_bound: exp %0h got %0h", e.bound, m_tdata[55:24]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last: exp %0d got %0d", e.last, m_tlast); fail_count++;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/pivot_lower_bound_knn_core_test.sv
module pivot_lower_bound_knn_core_test;
    logic        aclk;
    logic        aresetn;
    logic        cfg_valid, cfg_ready, cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid, s_tready, s_tlast;
    logic [87:0] s_tdata;   // obj_index, query_dist, table_dist (low to high)
    logic [1:0]  s_tuser;   // first_of_query, last_pivot
    logic        m_tvalid, m_tready, m_tlast, m_tuser;
    logic [55:0] m_tdata;   // neighbour_id, lower_bound
    int          fail_count, pending;
    bit          quiet;     // last part of the run: no idling
    bit          hold_sink; // long receiver hold-off request

    pivot_lower_bound_knn_core dut (.*);
    pivot_lower_bound_knn_checker chk (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // sink: random stall bursts, plus one long hold-off
    initial begin
        int n;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] v);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // stops the source, waits for every predicted word, then lets the core settle
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_pivot(input logic [23:0] id, input logic [31:0] q,
                              input logic [31:0] t, input logic fq,
                              input logic lp, input logic lo);
        int n;
        if (!quiet && !hold_sink && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            n = $urandom_range(1, 9);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {t, q, id};
        s_tuser <= {lp, fq};
        s_tlast <= lo;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // one query: objects of 1..4 pivots; mostly small distances so limits bite
    task automatic send_query(input int objs, input bit wide, input bit use_first);
        int p;
        logic [31:0] q, t;
        for (int o = 0; o < objs; o++) begin
            p = $urandom_range(1, 4);
            for (int j = 0; j < p; j++) begin
                q = wide ? $urandom : $urandom_range(0, 4000);
                t = wide ? $urandom : $urandom_range(0, 4000);
                send_pivot(24'($urandom), q, t, use_first && o == 0 && j == 0,
                           (j == p - 1) ? 1'b1 : 1'b0,
                           (o == objs - 1 && j == p - 1) ? 1'b1 : 1'b0);
            end
        end
    endtask

    initial begin
        int cnt;
        aresetn = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = 0; s_tlast = 0;
        quiet = 0; hold_sink = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset settings, extremes, limit equality, empty list
        send_pivot(24'hFFFFFF, 32'hFFFFFFFF, 32'h0, 1, 1, 0);
        send_pivot(24'h0, 32'h0, 32'hFFFFFFFF, 0, 0, 0);
        send_pivot(24'h000001, 32'h5, 32'h5, 0, 0, 1); // last object w/o last pivot
        drain();
        write_reg(plbk_pkg::REG_NEIGHBOURS_WANTED, 32'd3);
        write_reg(plbk_pkg::REG_SEARCH_RANGE, 32'd100);
        send_pivot(24'h10, 32'd200, 32'd100, 1, 1, 0); // diff == limit: kept
        send_pivot(24'h11, 32'd100, 32'd201, 0, 1, 0); // over limit: dropped
        send_pivot(24'h12, 32'd50, 32'd40, 0, 1, 0);
        send_pivot(24'h13, 32'd40, 32'd50, 0, 1, 0);   // equal bounds keep order
        send_pivot(24'h14, 32'd0, 32'd5, 0, 1, 0);     // displaces the largest
        send_pivot(24'h15, 32'd900, 32'd0, 0, 1, 1);
        send_pivot(24'h16, 32'd900, 32'd0, 0, 1, 1);   // empty list, no first
        drain();
        write_reg(plbk_pkg::REG_NEIGHBOURS_WANTED, 32'd0);
        write_reg(plbk_pkg::REG_SEARCH_RANGE, 32'hFFFFFFFF);
        send_query(3, 1, 1);
        drain();
        write_reg(plbk_pkg::REG_NEIGHBOURS_WANTED, 32'd31);
        write_reg(plbk_pkg::REG_SEARCH_RANGE, 32'd0);
        send_query(4, 1, 1);
        drain();

        // long hold-off: sink stalls while the source keeps offering
        write_reg(plbk_pkg::REG_NEIGHBOURS_WANTED, 32'd16);
        hold_sink = 1;
        for (int i = 0; i < 4; i++) send_query(5, 0, 1);
        drain();

        // random phases over several settings
        cnt = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(plbk_pkg::REG_NEIGHBOURS_WANTED, $urandom_range(0, 31));
            write_reg(plbk_pkg::REG_SEARCH_RANGE, ($urandom_range(0, 2) == 0) ? 32'd0 :
                      $urandom_range(0, 3000));
            if (ph == 5) quiet = 1;
            for (int qn = 0; qn < 3; qn++) begin
                if ($urandom_range(0, 7) == 0)
                    send_pivot(24'($urandom), $urandom, $urandom, 1'($urandom),
                               1'($urandom), 0);
                send_query($urandom_range(1, 6), $urandom_range(0, 3) == 0,
                           $urandom_range(0, 4) != 0);
            end
            drain(); // source pauses until every result is back
        end

        if (fail_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: files.f
rtl/plbk_pkg.sv
rtl/plbk_ctrl.sv
rtl/plbk_dp.sv
rtl/pivot_lower_bound_knn_core.sv
verif/pivot_lower_bound_knn_checker.sv
verif/pivot_lower_bound_knn_core_test.sv
